@@ hdl/spfw_pkg.sv @@
// Shared types and constants for the speed PI controller with field weakening.
// Holds fixed-point formats, register indexes and the control/datapath handshake structs.
// No dependencies.
package spfw_pkg;

  // Fixed-point formats
  localparam int SPEED_FRAC_BITS   = 8;
  localparam int STEP_FRAC_BITS    = 16;
  localparam int CURRENT_FRAC_BITS = 16;

  // Field and state widths
  localparam int GAIN_WIDTH     = 24;
  localparam int STEP_WIDTH     = 16;
  localparam int NOM_WIDTH      = 23;
  localparam int CUR_WIDTH      = 32;
  localparam int INTEG_WIDTH    = 48;
  localparam int INTEG_HALF     = 24;
  localparam int MUL_B_WIDTH    = 25;
  localparam int ACC_WIDTH      = 73;
  localparam int QUOT_WIDTH     = 32;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int CFG_IDX_WIDTH  = 3;

  typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t REG_SPEED_REF = 3'd0;
  localparam cfg_idx_t REG_KP        = 3'd1;
  localparam cfg_idx_t REG_KI        = 3'd2;
  localparam cfg_idx_t REG_HALF_STEP = 3'd3;
  localparam cfg_idx_t REG_NOM_SPEED = 3'd4;
  localparam cfg_idx_t REG_NOM_D_CUR = 3'd5;

  // Register reset values
  localparam logic [GAIN_WIDTH-1:0] KP_RST        = 24'd655360;
  localparam logic [GAIN_WIDTH-1:0] KI_RST        = 24'd655;
  localparam logic [STEP_WIDTH-1:0] HALF_STEP_RST = 16'd3277;
  localparam logic [NOM_WIDTH-1:0]  NOM_SPEED_RST = 23'd768000;

  // Operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_IDLE,
    MUL_INTEG,
    MUL_ILO,
    MUL_IHI,
    MUL_PROP,
    MUL_FW
  } mul_op_e;

  typedef struct packed {
    logic    load_meas;
    logic    calc_err;
    mul_op_e mul_op;
    logic    upd_integ;
    logic    div_start;
    logic    acc_load;
    logic    acc_add;
    logic    sum_q;
    logic    load_out;
  } spfw_cmd_t;

  typedef struct packed {
    logic weak_act;
    logic div_busy;
  } spfw_status_t;

endpackage

@@ hdl/spfw_div.sv @@
// Radix-2 restoring divider for the field-weakening quotient, one bit per cycle.
// Depends on spfw_pkg. Quotient must fit QUOT_WIDTH bits (high numerator part < divisor).
module spfw_div #(
  parameter int DIVISOR_W = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [DIVISOR_W-1:0]               numer_hi_i,
  input  logic [spfw_pkg::QUOT_WIDTH-1:0]    numer_lo_i,
  input  logic [DIVISOR_W-1:0]               divisor_i,
  output logic                               busy_o,
  output logic [spfw_pkg::QUOT_WIDTH-1:0]    quot_o
);
  import spfw_pkg::*;

  localparam int CNT_W = $clog2(QUOT_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_WIDTH - 1);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [QUOT_WIDTH-1:0] quo_q;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;

  // one trial subtraction; numerator bits shift out as quotient bits shift in
  assign rem_sh = {rem_q, quo_q[QUOT_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= numer_hi_i;
      quo_q <= numer_lo_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[DIVISOR_W]) begin
        rem_q <= diff[DIVISOR_W-1:0];
      end else begin
        rem_q <= rem_sh[DIVISOR_W-1:0];
      end
      quo_q <= {quo_q[QUOT_WIDTH-2:0], ~diff[DIVISOR_W]};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

@@ hdl/spfw_dp.sv @@
// Datapath: config registers, loop state, shared multiplier, accumulators, output word.
// Depends on spfw_pkg and spfw_div; sequenced by spfw_ctrl through spfw_cmd_t.
module spfw_dp #(
  parameter int SPEED_WIDTH    = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  spfw_pkg::cfg_idx_t                   cfg_index_i,
  input  logic [spfw_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i,
  input  logic [SPEED_WIDTH-1:0]               meas_i,
  input  spfw_pkg::spfw_cmd_t                  cmd_i,
  output spfw_pkg::spfw_status_t               status_o,
  output logic [spfw_pkg::CUR_WIDTH-1:0]       q_o,
  output logic [spfw_pkg::CUR_WIDTH-1:0]       d_o,
  output logic                                 weak_o,
  output logic                                 sat_o
);
  import spfw_pkg::*;

  localparam int ERR_W   = SPEED_WIDTH + 1;
  localparam int SUM_W   = SPEED_WIDTH + 2;
  localparam int MUL_A_W = (SPEED_WIDTH + 2 > CUR_WIDTH + 1) ? SPEED_WIDTH + 2 : CUR_WIDTH + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_WIDTH;
  localparam int NEW_W   = ((INTEG_WIDTH > PROD_W) ? INTEG_WIDTH : PROD_W) + 1;
  localparam int QW      = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
  localparam int CMP_W   = (SPEED_WIDTH > NOM_WIDTH + 1) ? SPEED_WIDTH : NOM_WIDTH + 1;
  localparam int INTEG_SHIFT =
    SPEED_FRAC_BITS + STEP_FRAC_BITS + GAIN_FRAC_BITS - CURRENT_FRAC_BITS;
  localparam int PROP_SHIFT = SPEED_FRAC_BITS + GAIN_FRAC_BITS - CURRENT_FRAC_BITS;

  localparam logic signed [NEW_W-1:0] IMAX = NEW_W'({1'b0, {(INTEG_WIDTH-1){1'b1}}});
  localparam logic signed [NEW_W-1:0] IMIN = ~IMAX;
  localparam logic signed [QW-1:0]    QMAX = QW'({1'b0, {(CUR_WIDTH-1){1'b1}}});
  localparam logic signed [QW-1:0]    QMIN = ~QMAX;

  // configuration registers
  logic signed [SPEED_WIDTH-1:0] speed_ref_q;
  logic [GAIN_WIDTH-1:0]         kp_q;
  logic [GAIN_WIDTH-1:0]         ki_q;
  logic [STEP_WIDTH-1:0]         hstep_q;
  logic [NOM_WIDTH-1:0]          nom_q;
  logic signed [CUR_WIDTH-1:0]   dnom_q;

  // loop state
  logic signed [ERR_W-1:0]       prev_q;
  logic signed [INTEG_WIDTH-1:0] integ_q;

  // per-word working registers
  logic signed [SPEED_WIDTH-1:0] meas_q;
  logic signed [ERR_W-1:0]       err_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_WIDTH-1:0]   acc_q;
  logic signed [CUR_WIDTH-1:0]   q_q;
  logic                          weak_q;
  logic                          sat_q;

  // output word
  logic [CUR_WIDTH-1:0]          q_out_q;
  logic [CUR_WIDTH-1:0]          d_out_q;
  logic                          weak_out_q;
  logic                          sat_out_q;

  logic signed [SUM_W-1:0]       err_sum;
  logic [CUR_WIDTH-1:0]          dmag;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_WIDTH-1:0] mul_b;
  logic signed [NEW_W-1:0]       integ_new;
  logic signed [ACC_WIDTH-1:0]   iterm;
  logic signed [PROD_W-1:0]      pterm;
  logic signed [QW-1:0]          q_wide;
  logic [QUOT_WIDTH-1:0]         quot;
  logic                          div_busy;

  assign err_sum = SUM_W'(err_q) + SUM_W'(prev_q);
  assign dmag    = dnom_q[CUR_WIDTH-1] ? (~dnom_q + 1'b1) : dnom_q;

  // config writes; unknown indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_ref_q <= '0;
      kp_q        <= KP_RST;
      ki_q        <= KI_RST;
      hstep_q     <= HALF_STEP_RST;
      nom_q       <= NOM_SPEED_RST;
      dnom_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SPEED_REF: speed_ref_q <= cfg_data_i[SPEED_WIDTH-1:0];
        REG_KP:        kp_q        <= cfg_data_i[GAIN_WIDTH-1:0];
        REG_KI:        ki_q        <= cfg_data_i[GAIN_WIDTH-1:0];
        REG_HALF_STEP: hstep_q     <= cfg_data_i[STEP_WIDTH-1:0];
        REG_NOM_SPEED: nom_q       <= cfg_data_i[NOM_WIDTH-1:0];
        REG_NOM_D_CUR: dnom_q      <= cfg_data_i[CUR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_INTEG: begin
        mul_a = MUL_A_W'(err_sum);
        mul_b = MUL_B_WIDTH'({1'b0, hstep_q});
      end
      MUL_ILO: begin
        mul_a = MUL_A_W'({1'b0, integ_q[INTEG_HALF-1:0]});
        mul_b = MUL_B_WIDTH'({1'b0, ki_q});
      end
      MUL_IHI: begin
        mul_a = MUL_A_W'($signed(integ_q[INTEG_WIDTH-1:INTEG_HALF]));
        mul_b = MUL_B_WIDTH'({1'b0, ki_q});
      end
      MUL_PROP: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = MUL_B_WIDTH'({1'b0, kp_q});
      end
      MUL_FW: begin
        mul_a = MUL_A_W'({1'b0, dmag});
        mul_b = MUL_B_WIDTH'({1'b0, nom_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // integrator update with clamp to 48 bits
  assign integ_new = NEW_W'(integ_q) + NEW_W'(prod_q);

  // q sum: integral term (accumulated 72-bit product) plus proportional term
  assign iterm  = acc_q >>> INTEG_SHIFT;
  assign pterm  = prod_q >>> PROP_SHIFT;
  assign q_wide = QW'(iterm) + QW'(pterm);

  // loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
    end else if (cmd_i.upd_integ) begin
      prev_q <= err_q;
      if (integ_new > IMAX) begin
        integ_q <= INTEG_WIDTH'(IMAX);
      end else if (integ_new < IMIN) begin
        integ_q <= INTEG_WIDTH'(IMIN);
      end else begin
        integ_q <= INTEG_WIDTH'(integ_new);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_meas) begin
      meas_q <= meas_i;
    end
    if (cmd_i.calc_err) begin
      err_q  <= ERR_W'(speed_ref_q) - ERR_W'(meas_q);
      weak_q <= $signed(CMP_W'(meas_q)) > $signed(CMP_W'({1'b0, nom_q}));
    end
    if (cmd_i.mul_op != MUL_IDLE) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd_i.upd_integ) begin
      sat_q <= (integ_new > IMAX) || (integ_new < IMIN);
    end
    if (cmd_i.acc_load) begin
      acc_q <= ACC_WIDTH'(prod_q);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + (ACC_WIDTH'(prod_q) <<< INTEG_HALF);
    end
    if (cmd_i.sum_q) begin
      if (q_wide > QMAX) begin
        q_q   <= CUR_WIDTH'(QMAX);
        sat_q <= 1'b1;
      end else if (q_wide < QMIN) begin
        q_q   <= CUR_WIDTH'(QMIN);
        sat_q <= 1'b1;
      end else begin
        q_q <= CUR_WIDTH'(q_wide);
      end
    end
    // output word
    if (cmd_i.load_out) begin
      q_out_q    <= q_q;
      weak_out_q <= weak_q;
      sat_out_q  <= sat_q;
      if (!weak_q) begin
        d_out_q <= dnom_q;
      end else if (dnom_q[CUR_WIDTH-1]) begin
        d_out_q <= ~quot + 1'b1;
      end else begin
        d_out_q <= quot;
      end
    end
  end

  // field-weakening quotient |d| * nominal / measured
  spfw_div #(
    .DIVISOR_W (SPEED_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .numer_hi_i (SPEED_WIDTH'(prod_q >>> QUOT_WIDTH)),
    .numer_lo_i (prod_q[QUOT_WIDTH-1:0]),
    .divisor_i  (meas_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign status_o.weak_act = weak_q;
  assign status_o.div_busy = div_busy;
  assign q_o    = q_out_q;
  assign d_o    = d_out_q;
  assign weak_o = weak_out_q;
  assign sat_o  = sat_out_q;

endmodule

@@ hdl/spfw_ctrl.sv @@
// Sequencer: steps one speed sample through the datapath and owns the stream handshakes.
// Depends on spfw_pkg; drives spfw_dp through spfw_cmd_t.
module spfw_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  spfw_pkg::spfw_status_t status_i,
  output spfw_pkg::spfw_cmd_t    cmd_o
);
  import spfw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_INT,
    ST_UPD_INT,
    ST_MUL_ILO,
    ST_MUL_IHI,
    ST_MUL_PROP,
    ST_SUM_Q,
    ST_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   go;

  // result may leave once the quotient is done and the output register is free
  assign go = !status_i.div_busy && (!out_valid_q || out_ready_i);

  // commands and next state
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_op  = MUL_IDLE;
    state_d       = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_meas = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd_o.calc_err = 1'b1;
        state_d        = ST_MUL_INT;
      end
      ST_MUL_INT: begin
        cmd_o.mul_op = MUL_INTEG;
        state_d      = ST_UPD_INT;
      end
      ST_UPD_INT: begin
        cmd_o.upd_integ = 1'b1;
        cmd_o.mul_op    = MUL_FW;
        state_d         = ST_MUL_ILO;
      end
      ST_MUL_ILO: begin
        cmd_o.div_start = status_i.weak_act;
        cmd_o.mul_op    = MUL_ILO;
        state_d         = ST_MUL_IHI;
      end
      ST_MUL_IHI: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.mul_op   = MUL_IHI;
        state_d        = ST_MUL_PROP;
      end
      ST_MUL_PROP: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.mul_op  = MUL_PROP;
        state_d       = ST_SUM_Q;
      end
      ST_SUM_Q: begin
        cmd_o.sum_q = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        cmd_o.load_out = go;
        if (go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_WAIT && go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/speed_pi_with_field_weakening_top.sv @@
// Channel     Dir  Payload (low bit first)                         Accept
// s_axis      in   tdata: measured_speed                           tvalid & tready
// m_axis      out  tdata: q_current_ref, d_current_ref;            tvalid & tready
//                  tuser: weakening_active, saturated
// cfg         in   cfg_index_i: register, cfg_data_i: value        cfg_valid_i & cfg_ready_o
//
// Above nominal speed a speed word's result also waits for the 32-step radix-2 divider of
// the weakening quotient; at or below nominal speed the divider is not started.
// Five products go through one shared multiplier, one per cycle.
// One word is in work at a time; the next is taken while the result waits in the output register.
// Reset clears the loop state and loads the register defaults; config is taken at any cycle.
// Top level; depends on spfw_pkg, spfw_ctrl, spfw_dp, spfw_div.
module speed_pi_with_field_weakening_top #(
  parameter int SPEED_WIDTH    = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tdata: measured_speed [SPEED_WIDTH-1:0], zero fill to bytes
  input  logic [((SPEED_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: q_current_ref [31:0], d_current_ref [63:32]
  output logic [2*spfw_pkg::CUR_WIDTH-1:0]     m_axis_tdata,
  // tuser: weakening_active [0], saturated [1]
  output logic [1:0]                           m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  spfw_pkg::cfg_idx_t                   cfg_index_i,
  input  logic [spfw_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i
);
  import spfw_pkg::*;

  spfw_cmd_t            cmd;
  spfw_status_t         status;
  logic [CUR_WIDTH-1:0] q_cur;
  logic [CUR_WIDTH-1:0] d_cur;
  logic                 weak_act;
  logic                 sat;

  spfw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spfw_dp #(
    .SPEED_WIDTH    (SPEED_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .meas_i      (s_axis_tdata[SPEED_WIDTH-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .q_o         (q_cur),
    .d_o         (d_cur),
    .weak_o      (weak_act),
    .sat_o       (sat)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {d_cur, q_cur};
  assign m_axis_tuser = {sat, weak_act};

endmodule

@@ hdl/spfw_checker.sv @@
// Port-level checks for the speed PI controller top level, attached by bind.
// Depends on speed_pi_with_field_weakening_top port names.
module spfw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // one word in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in work");

  // a result never appears right after the accept that caused it
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared one cycle after accept");

  // stalled result stays offered
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn under stall");

  // stalled result word holds
  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed under stall");

endmodule

bind speed_pi_with_field_weakening_top spfw_checker u_spfw_checker (.*);

@@ tb/speed_pi_with_field_weakening_top_tb.sv @@
// Self-checking bench for the speed PI loop with field weakening: random-gap stream
// driver, stalling result monitor and a cycle-free predictor of the control step.
// Depends on spfw_pkg and speed_pi_with_field_weakening_top.
module speed_pi_with_field_weakening_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spfw_pkg::*;

  localparam int SPEED_WIDTH    = 24;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int INTEG_SHIFT    = SPEED_FRAC_BITS + STEP_FRAC_BITS + GAIN_FRAC_BITS
                                  - CURRENT_FRAC_BITS;
  localparam int PROP_SHIFT     = SPEED_FRAC_BITS + GAIN_FRAC_BITS - CURRENT_FRAC_BITS;
  localparam longint INTEG_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_MIN  = -INTEG_MAX - 1;
  localparam longint Q_HI       = 64'sd2147483647;
  localparam longint Q_LO       = -Q_HI - 1;
  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int MAX_GAP        = 19;
  localparam int MAX_REPORTS    = 10;

  // Indexes outside the register map; writes there must leave everything alone
  localparam cfg_idx_t REG_SPARE_LO = 3'd6;
  localparam cfg_idx_t REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [31:0] q_cur;
    logic [31:0] d_cur;
    logic        weak_on;
    logic        sat;
  } current_refs_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic [23:0] s_axis_tdata  = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_t    cfg_index_i   = '0;
  logic [31:0] cfg_data_i    = '0;

  speed_pi_with_field_weakening_top #(
    .SPEED_WIDTH   (SPEED_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Register copies and loop state of the predictor
  logic [23:0] spd_ref_r   = '0;
  logic [23:0] kp_r        = KP_RST;
  logic [23:0] ki_r        = KI_RST;
  logic [15:0] half_step_r = HALF_STEP_RST;
  logic [22:0] nom_speed_r = NOM_SPEED_RST;
  logic [31:0] nom_d_r     = '0;
  longint      prev_err_st = 0;
  longint      integ_st    = 0;

  logic [23:0]   speed_words_q [$];
  current_refs_t current_refs_q [$];

  int   in_gap_max    = 0;
  int   out_stall_max = 0;
  int   word_gap      = 0;
  int   result_stall  = 0;
  int   idle_cycles   = 0;
  int   fail_cnt      = 0;
  logic in_taken      = 1'b0;
  logic out_taken     = 1'b0;

  // One control tick: trapezoidal PI on the speed error, then field weakening
  function automatic current_refs_t run_speed_loop(input logic [23:0] speed_word);
    longint meas, err, sum, dnom, mag, quot;
    logic signed [79:0] integ_w, ki_w, err_w, kp_w, q_wide;
    current_refs_t r;
    meas = longint'($signed(speed_word));
    err  = longint'($signed(spd_ref_r)) - meas;
    r.sat = 1'b0;

    sum = integ_st + (err + prev_err_st) * longint'(half_step_r);
    if (sum > INTEG_MAX) begin
      sum = INTEG_MAX;
      r.sat = 1'b1;
    end else if (sum < INTEG_MIN) begin
      sum = INTEG_MIN;
      r.sat = 1'b1;
    end
    integ_st    = sum;
    prev_err_st = err;

    // both terms drop bits, i.e. floor toward minus infinity
    integ_w = sum;
    ki_w    = ki_r;
    err_w   = err;
    kp_w    = kp_r;
    q_wide  = ((integ_w * ki_w) >>> INTEG_SHIFT) + ((err_w * kp_w) >>> PROP_SHIFT);
    if (q_wide > Q_HI) begin
      q_wide = Q_HI;
      r.sat = 1'b1;
    end else if (q_wide < Q_LO) begin
      q_wide = Q_LO;
      r.sat = 1'b1;
    end
    r.q_cur = q_wide[31:0];

    // d reference scaled by nominal / measured above nominal, quotient toward zero
    dnom = longint'($signed(nom_d_r));
    r.weak_on = meas > longint'(nom_speed_r);
    if (r.weak_on) begin
      mag  = (dnom < 0) ? -dnom : dnom;
      quot = (mag * longint'(nom_speed_r)) / meas;
      dnom = (dnom < 0) ? -quot : quot;
    end
    r.d_cur = dnom[31:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t mismatch %s: expected %0d (0x%h), got %0d (0x%h)", $realtime, name,
                 $signed(want), want, $signed(got), got);
    end
  endfunction

  // Register value: an extreme, a typical value or random, with junk above the width
  function automatic logic [31:0] pick_reg_value(int width, bit is_signed,
                                                 logic [31:0] typical);
    logic [31:0] mask, v;
    mask = (width == 32) ? 32'hFFFF_FFFF : (32'd1 << width) - 32'd1;
    case ($urandom_range(0, 3))
      0:       v = is_signed ? (32'd1 << (width - 1)) : 32'd0;
      1:       v = is_signed ? (mask >> 1) : mask;
      2:       v = typical;
      default: v = $urandom;
    endcase
    return (v & mask) | ($urandom & ~mask);
  endfunction

  // Speed sample: bias 1 stays near the negative end, bias 2 near the positive end
  function automatic logic [23:0] pick_speed(int bias);
    logic [23:0] s;
    case (bias)
      1: s = {3'b100, 21'($urandom)};
      2: s = {3'b011, 21'($urandom)};
      default: begin
        case ($urandom_range(0, 5))
          0: s = 24'($urandom);
          1: s = {1'b0, nom_speed_r} + 24'($urandom_range(0, 4)) - 24'd2;
          2: s = spd_ref_r + 24'($urandom_range(0, 512)) - 24'd256;
          3: s = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
          4: s = 24'($signed(12'($urandom)));
          default: s = {1'b0, 23'($urandom)};
        endcase
      end
    endcase
    return s;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SPEED_REF: spd_ref_r   = value[23:0];
      REG_KP:        kp_r        = value[23:0];
      REG_KI:        ki_r        = value[23:0];
      REG_HALF_STEP: half_step_r = value[15:0];
      REG_NOM_SPEED: nom_speed_r = value[22:0];
      REG_NOM_D_CUR: nom_d_r     = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Returns once every queued word went in and every result came back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (speed_words_q.size() != 0 || s_axis_tvalid || current_refs_q.size() != 0);
  endtask

  // Speed word driver with a random gap before each word
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (word_gap > 0) begin
          word_gap = word_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (speed_words_q.size() != 0) begin
          s_axis_tdata  <= speed_words_q.pop_front();
          s_axis_tvalid <= 1'b1;
          word_gap = $urandom_range(0, in_gap_max);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result back-pressure: a random stall after each accepted result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken)
        result_stall = $urandom_range(0, out_stall_max);
      if (result_stall > 0) begin
        result_stall = result_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    current_refs_t want;
    in_taken  <= s_axis_tvalid && s_axis_tready;
    out_taken <= m_axis_tvalid && m_axis_tready;
    if (s_axis_tvalid && s_axis_tready)
      current_refs_q.push_back(run_speed_loop(s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      if (current_refs_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t result word with no speed word pending: tdata 0x%h tuser %b",
                   $realtime, m_axis_tdata, m_axis_tuser);
      end else begin
        want = current_refs_q.pop_front();
        check_field("q_current_ref", want.q_cur, m_axis_tdata[31:0]);
        check_field("d_current_ref", want.d_cur, m_axis_tdata[63:32]);
        check_field("weakening_active", 32'(want.weak_on), 32'(m_axis_tuser[0]));
        check_field("saturated", 32'(want.sat), 32'(m_axis_tuser[1]));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n_words;
    int bias;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Corner speeds under reset defaults, with gaps on both sides
    in_gap_max    = MAX_GAP;
    out_stall_max = MAX_GAP;
    speed_words_q.push_back(24'd0);      speed_words_q.push_back(24'd1);
    speed_words_q.push_back(24'hFF_FFFF); speed_words_q.push_back(24'd768000);
    speed_words_q.push_back(24'd768001); speed_words_q.push_back(24'h7F_FFFF);
    speed_words_q.push_back(24'h80_0000); speed_words_q.push_back(24'd256);
    speed_words_q.push_back(24'hFF_FF00); speed_words_q.push_back(24'd12345);
    wait_drained();

    // Top gains, zero nominal speed, most negative d current; spare indexes ignored
    in_gap_max    = 0;
    out_stall_max = 0;
    write_reg(REG_SPEED_REF, 32'h007F_FFFF);
    write_reg(REG_KP, 32'h00FF_FFFF);
    write_reg(REG_KI, 32'h00FF_FFFF);
    write_reg(REG_HALF_STEP, 32'h0000_FFFF);
    write_reg(REG_NOM_SPEED, 32'h0000_0000);
    write_reg(REG_NOM_D_CUR, 32'h8000_0000);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h1234_5678);
    repeat (4) speed_words_q.push_back(24'h80_0000);
    speed_words_q.push_back(24'd1);      speed_words_q.push_back(24'h7F_FFFF);
    speed_words_q.push_back(24'd0);      speed_words_q.push_back(24'hFF_FFFF);
    wait_drained();

    // Zero gains and step, top nominal speed, most positive d current
    in_gap_max = MAX_GAP;
    write_reg(REG_SPEED_REF, 32'hFF80_0000);
    write_reg(REG_KP, 32'h0000_0000);
    write_reg(REG_KI, 32'h0000_0000);
    write_reg(REG_HALF_STEP, 32'h0000_0000);
    write_reg(REG_NOM_SPEED, 32'h007F_FFFF);
    write_reg(REG_NOM_D_CUR, 32'h7FFF_FFFF);
    speed_words_q.push_back(24'h7F_FFFF); speed_words_q.push_back(24'h80_0000);
    speed_words_q.push_back(24'd1);      speed_words_q.push_back(24'd0);
    wait_drained();

    // Random phases, each with fresh settings and its own idling mode
    for (int ph = 0; ph < 13; ph++) begin
      in_gap_max    = (ph % 4 == 1 || ph % 4 == 3) ? MAX_GAP : 0;
      out_stall_max = (ph % 4 == 2 || ph % 4 == 3) ? MAX_GAP : 0;
      write_reg(REG_SPEED_REF, pick_reg_value(24, 1'b1, 32'($urandom_range(0, 600000))));
      write_reg(REG_KP, pick_reg_value(24, 1'b0, 32'(KP_RST)));
      write_reg(REG_KI, pick_reg_value(24, 1'b0, 32'(KI_RST)));
      write_reg(REG_HALF_STEP, pick_reg_value(16, 1'b0, 32'(HALF_STEP_RST)));
      write_reg(REG_NOM_SPEED, pick_reg_value(23, 1'b0, 32'(NOM_SPEED_RST)));
      write_reg(REG_NOM_D_CUR, pick_reg_value(32, 1'b1, 32'hFFFD_0000));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      bias    = 0;
      n_words = 40;
      // Integrator windup toward either rail
      if (ph == 4 || ph == 8) begin
        bias    = (ph == 4) ? 1 : 2;
        n_words = 100;
        write_reg(REG_SPEED_REF, (ph == 4) ? 32'h007F_FFFF : 32'h0080_0000);
        write_reg(REG_KI, 32'h00FF_FFFF);
        write_reg(REG_HALF_STEP, 32'h0000_FFFF);
      end
      for (int i = 0; i < n_words; i++) begin
        speed_words_q.push_back(pick_speed(bias));
        // hold the stream mid-phase until every result is back
        if (ph == 3 && i == n_words / 2)
          wait_drained();
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
